/* hw/rtl/swm_pkg.sv */
// shared constants, codes and types of the sliding window mean block
`timescale 1ns / 1ps
package swm_pkg;

	// window and datapath sizes
	localparam int WINDOW_MAX  = 4096;
	localparam int CNT_W       = $clog2(WINDOW_MAX + 1);
	localparam int VAL_W       = 32;
	localparam int SUM_W       = 44;
	localparam int DIV_CW      = $clog2(SUM_W);
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);
	localparam int CFG_IDX_W   = 2;

	// action codes on the input channel
	localparam logic [1:0] ACT_ADD    = 2'd0;
	localparam logic [1:0] ACT_REMOVE = 2'd1;
	localparam logic [1:0] ACT_QUERY  = 2'd2;

	// result kinds
	localparam logic [1:0] KIND_MEAN   = 2'd0;
	localparam logic [1:0] KIND_CENTRE = 2'd1;
	localparam logic [1:0] KIND_FILL   = 2'd2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_EXCL_EN    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_EXCL_VALUE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_REJECT_CTR = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_GOOD   = 2'd3;

	// classified operations passed from front to back
	typedef enum logic [2:0] {
		OP_ADD_GOOD,
		OP_REM_GOOD,
		OP_ADD_EXCL,
		OP_REM_EXCL,
		OP_QUERY
	} op_t;

	// back end sequencer states
	typedef enum logic [1:0] {
		BK_IDLE,
		BK_DIV,
		BK_FIN
	} bk_state_t;

	typedef struct packed {
		logic                    excl_en;
		logic signed [VAL_W-1:0] excl_value;
		logic                    reject_centre;
		logic [CNT_W-1:0]        min_good;
	} swm_cfg_t;

	typedef struct packed {
		op_t                     op;
		logic signed [VAL_W-1:0] value;
		logic                    centre_excl;
	} qentry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

	typedef struct packed {
		logic             dividing;
		logic [CNT_W-1:0] good_cnt;
		logic [CNT_W-1:0] excl_cnt;
	} bk_stat_t;

endpackage

/* hw/rtl/swm_ifs.sv */
// channel interfaces for input items and results
`timescale 1ns / 1ps
interface swm_in_if import swm_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic [1:0]              action;
	logic signed [VAL_W-1:0] item_value;
	logic                    item_present;

	modport source (output valid, action, item_value, item_present, input ready);
	modport sink (input valid, action, item_value, item_present, output ready);
endinterface

interface swm_out_if import swm_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic signed [VAL_W-1:0] result_value;
	logic                    result_valid;
	logic [1:0]              result_kind;

	modport source (output valid, result_value, result_valid, result_kind, input ready);
	modport sink (input valid, result_value, result_valid, result_kind, output ready);
endinterface

/* hw/rtl/swm_front.sv */
// front end: configuration registers, item acceptance and classification
`timescale 1ns / 1ps
module swm_front import swm_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [VAL_W-1:0]     cfg_data,
	swm_in_if.sink               item,
	input  logic                 q_full,
	output logic                 push,
	output qentry_t              push_ent,
	output swm_cfg_t             cfg
);

	swm_cfg_t cfg_q;
	logic     is_excl;
	logic     keep;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_EXCL_EN:    cfg_q.excl_en <= cfg_data[0];
				CFG_EXCL_VALUE: cfg_q.excl_value <= cfg_data;
				CFG_REJECT_CTR: cfg_q.reject_centre <= cfg_data[0];
				CFG_MIN_GOOD:   cfg_q.min_good <= cfg_data[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

	// classification of the incoming item
	assign is_excl = item.item_present && cfg_q.excl_en &&
		(item.item_value == cfg_q.excl_value);

	always_comb begin
		keep = 1'b0;
		push_ent.op = OP_QUERY;
		push_ent.value = item.item_value;
		push_ent.centre_excl = is_excl;
		case (item.action)
			ACT_ADD: begin
				keep = item.item_present;
				push_ent.op = is_excl ? OP_ADD_EXCL : OP_ADD_GOOD;
			end
			ACT_REMOVE: begin
				keep = item.item_present;
				push_ent.op = is_excl ? OP_REM_EXCL : OP_REM_GOOD;
			end
			ACT_QUERY: begin
				keep = 1'b1;
				push_ent.op = OP_QUERY;
			end
			default: keep = 1'b0;
		endcase
	end

	// missing samples and unknown actions are taken and dropped here
	assign item.ready = !q_full;
	assign push = item.valid && !q_full && keep;

endmodule

/* hw/rtl/swm_fifo.sv */
// short queue of classified operations between front and back
`timescale 1ns / 1ps
module swm_fifo import swm_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  qentry_t din,
	input  logic    pop,
	output qentry_t dout,
	output qstat_t  stat
);

	qentry_t             mem_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0] wr_ptr_q;
	logic [QUEUE_AW-1:0] rd_ptr_q;
	logic [QUEUE_CW-1:0] cnt_q;

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	assign dout = mem_q[rd_ptr_q];
	assign stat.full = (cnt_q == QUEUE_CW'(QUEUE_DEPTH));
	assign stat.empty = (cnt_q == '0);

endmodule

/* hw/rtl/swm_back.sv */
// back end: running sum and counters, query decision, serial divider, result register
`timescale 1ns / 1ps
module swm_back import swm_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  swm_cfg_t cfg,
	input  logic     q_empty,
	input  qentry_t  ent,
	output logic     pop,
	output bk_stat_t stat,
	swm_out_if.source result
);

	bk_state_t state_q, state_d;

	logic [SUM_W-1:0]  sum_q;
	logic [CNT_W-1:0]  good_q;
	logic [CNT_W-1:0]  excl_q;

	logic [SUM_W-1:0]  dvd_q;
	logic [CNT_W-1:0]  rem_q;
	logic [CNT_W-1:0]  divisor_q;
	logic [DIV_CW-1:0] cnt_q;
	logic              neg_q;

	logic                    res_valid_q;
	logic signed [VAL_W-1:0] res_value_q;
	logic                    res_ok_q;
	logic [1:0]              res_kind_q;

	logic                    out_free;
	logic                    start_div;
	logic                    load_res;
	logic signed [VAL_W-1:0] res_value_d;
	logic                    res_ok_d;
	logic [1:0]              res_kind_d;

	logic [SUM_W-1:0] sample_ext;
	logic [CNT_W:0]   trial;
	logic             trial_ge;
	logic             q_hi;
	logic             sat_neg;
	logic             sat_pos;
	logic [VAL_W-1:0] mean_val;

	assign out_free = !res_valid_q || result.ready;
	assign sample_ext = {{(SUM_W - VAL_W){ent.value[VAL_W-1]}}, ent.value};

	// divider step and saturation of the quotient
	assign trial = {rem_q, dvd_q[SUM_W-1]};
	assign trial_ge = (trial >= {1'b0, divisor_q});
	assign q_hi = |dvd_q[SUM_W-1:VAL_W];
	assign sat_neg = q_hi || (dvd_q[VAL_W-1] && (|dvd_q[VAL_W-2:0]));
	assign sat_pos = q_hi || dvd_q[VAL_W-1];

	always_comb begin
		if (neg_q) begin
			mean_val = sat_neg ? {1'b1, {(VAL_W - 1){1'b0}}} : (~dvd_q[VAL_W-1:0] + 1'b1);
		end else begin
			mean_val = sat_pos ? {1'b0, {(VAL_W - 1){1'b1}}} : dvd_q[VAL_W-1:0];
		end
	end

	// sequencer state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state, queue pop and result selection
	always_comb begin
		state_d = state_q;
		pop = 1'b0;
		start_div = 1'b0;
		load_res = 1'b0;
		res_value_d = '0;
		res_ok_d = 1'b0;
		res_kind_d = KIND_MEAN;
		case (state_q)
			BK_IDLE: begin
				if (!q_empty) begin
					if (ent.op == OP_QUERY) begin
						if (ent.centre_excl && cfg.reject_centre) begin
							if (out_free) begin
								pop = 1'b1;
								load_res = 1'b1;
								res_value_d = cfg.excl_value;
								res_ok_d = 1'b1;
								res_kind_d = KIND_CENTRE;
							end
						end else if (good_q > cfg.min_good) begin
							pop = 1'b1;
							start_div = 1'b1;
							state_d = BK_DIV;
						end else if (out_free) begin
							pop = 1'b1;
							load_res = 1'b1;
							if (cfg.excl_en && !cfg.reject_centre && (excl_q != '0)) begin
								res_value_d = cfg.excl_value;
								res_ok_d = 1'b1;
								res_kind_d = KIND_FILL;
							end
						end
					end else begin
						pop = 1'b1;
					end
				end
			end
			BK_DIV: begin
				if (cnt_q == '0) begin
					state_d = BK_FIN;
				end
			end
			BK_FIN: begin
				if (out_free) begin
					load_res = 1'b1;
					res_value_d = mean_val;
					res_ok_d = 1'b1;
					res_kind_d = KIND_MEAN;
					state_d = BK_IDLE;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	// running sum and saturating counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			good_q <= '0;
			excl_q <= '0;
		end else if (pop) begin
			case (ent.op)
				OP_ADD_GOOD: begin
					if (good_q != CNT_W'(WINDOW_MAX)) begin
						sum_q <= sum_q + sample_ext;
						good_q <= good_q + 1'b1;
					end
				end
				OP_REM_GOOD: begin
					if (good_q != '0) begin
						sum_q <= sum_q - sample_ext;
						good_q <= good_q - 1'b1;
					end
				end
				OP_ADD_EXCL: begin
					if (excl_q != CNT_W'(WINDOW_MAX)) begin
						excl_q <= excl_q + 1'b1;
					end
				end
				OP_REM_EXCL: begin
					if (excl_q != '0) begin
						excl_q <= excl_q - 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	// restoring divider, one quotient bit a cycle
	always_ff @(posedge clk) begin
		if (start_div) begin
			neg_q <= sum_q[SUM_W-1];
			dvd_q <= sum_q[SUM_W-1] ? (~sum_q + 1'b1) : sum_q;
			rem_q <= '0;
			divisor_q <= good_q;
			cnt_q <= DIV_CW'(SUM_W - 1);
		end else if (state_q == BK_DIV) begin
			rem_q <= trial_ge ? CNT_W'(trial - {1'b0, divisor_q}) : trial[CNT_W-1:0];
			dvd_q <= {dvd_q[SUM_W-2:0], trial_ge};
			cnt_q <= cnt_q - 1'b1;
		end
	end

	// result output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (load_res) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_res) begin
			res_value_q <= res_value_d;
			res_ok_q <= res_ok_d;
			res_kind_q <= res_kind_d;
		end
	end

	assign result.valid = res_valid_q;
	assign result.result_value = res_value_q;
	assign result.result_valid = res_ok_q;
	assign result.result_kind = res_kind_q;

	assign stat.dividing = (state_q == BK_DIV);
	assign stat.good_cnt = good_q;
	assign stat.excl_cnt = excl_q;

endmodule

/* hw/rtl/sliding_window_mean_with_exclusion_top.sv */
// top level of the sliding window mean with exclusion block
// add and remove transactions: one per cycle while the queue has room, applied on pop
// query without a mean: result registered when popped while the output is free
// query with a mean: result from the 44-step serial divider in the back end, registered
// in the finishing state; the back end takes no other operation while the divider runs
// asynchronous active-low reset clears sums, counters, configuration and the queue
`timescale 1ns / 1ps
module sliding_window_mean_with_exclusion_top import swm_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [VAL_W-1:0]     cfg_data,
	swm_in_if.sink               item,
	swm_out_if.source            result
);

	swm_cfg_t cfg;
	logic     q_push;
	logic     q_pop;
	qentry_t  q_din;
	qentry_t  q_dout;
	qstat_t   q_stat;
	bk_stat_t bk_stat;

	// accept and classify
	swm_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.item      (item),
		.q_full    (q_stat.full),
		.push      (q_push),
		.push_ent  (q_din),
		.cfg       (cfg)
	);

	// operation queue
	swm_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.din    (q_din),
		.pop    (q_pop),
		.dout   (q_dout),
		.stat   (q_stat)
	);

	// execute and answer
	swm_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.q_empty (q_stat.empty),
		.ent     (q_dout),
		.pop     (q_pop),
		.stat    (bk_stat),
		.result  (result)
	);

	// the back end only takes operations that are really queued
	a_pop_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_stat.empty)
		else $error("queue popped while empty");

	// nothing leaves the queue while the divider runs
	a_no_pop_dividing: assert property (@(posedge clk) disable iff (!arst_n)
		bk_stat.dividing |-> !q_pop)
		else $error("queue popped during division");

	// counters stay within the window
	a_counts_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		(bk_stat.good_cnt <= CNT_W'(WINDOW_MAX)) && (bk_stat.excl_cnt <= CNT_W'(WINDOW_MAX)))
		else $error("window counter beyond window size");

	// a division ends in the finishing state, which takes nothing from the queue
	a_div_exit: assert property (@(posedge clk) disable iff (!arst_n)
		($past(bk_stat.dividing) && !bk_stat.dividing) |-> !q_pop)
		else $error("division left early");

endmodule
